@@ hdl/pes_pkg.sv @@
// Shared types and constants for the periodic event scheduler.
// Request and response beat layouts, table entry layout, codes and sizes.
// No dependencies.
`default_nettype none

package pes_pkg;

  localparam int unsigned MaxSources = 64;
  localparam int unsigned IdxW       = (MaxSources > 1) ? $clog2(MaxSources) : 1;
  localparam int unsigned CntW       = IdxW + 1;

  localparam int unsigned IdW     = 32;
  localparam int unsigned PeriodW = 20;
  localparam int unsigned TimeW   = 32;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqNext   = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [IdW-1:0]     source_id;
    logic [PeriodW-1:0] period;
  } pes_req_t;

  typedef struct packed {
    logic [IdW-1:0]   event_id;
    logic [TimeW-1:0] event_time;
    logic [1:0]       status;
  } pes_rsp_t;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   next_time;
  } pes_entry_t;

  localparam int unsigned EntryW = $bits(pes_entry_t);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite
  } pes_state_e;

endpackage

`default_nettype wire

@@ hdl/pes_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port.
// The read data is registered. No dependencies.
`default_nettype none

// Depth must be at least two so that the address width below is never zero; the module does not enforce it.
module pes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   waddr_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic [$clog2(Depth)-1:0]   raddr_i,
  output logic      [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/periodic_event_scheduler.sv @@
// Periodic event scheduler. Insert, clear and empty-table requests post their response at
// the accepting edge, so such beats can follow one per cycle while out_ready_i is high.
// A next request scans one entry per cycle through the table RAM's read port and writes
// the winner back in the state after the scan, which posts its response; a next request
// is taken only once the scheduler is idle again. Reset (rst_ni low, asynchronous) empties
// the table and drops any pending response; stale RAM slots above the count are never used.
`default_nettype none

module periodic_event_scheduler
  import pes_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pes_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output pes_rsp_t      out_data_o
);

  // Control state.
  pes_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            out_valid_q, out_valid_d;

  // Payload state.
  pes_rsp_t        out_q, out_d;
  pes_entry_t      best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;

  // Table RAM signals.
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  pes_entry_t      ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  pes_entry_t      rd_entry;

  logic            accept;
  logic            scan_last;
  logic            take;
  logic [TimeW:0]  time_sum;
  logic [TimeW-1:0] time_next;

  assign rd_entry = pes_entry_t'(ram_rdata);

  // A request is taken only while idle and with the response slot free (or being drained),
  // so the response of any request always finds the output register empty.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The scan finishes when the entry arriving from the RAM is the last valid one.
  assign scan_last = ({1'b0, cmp_idx_q} == (count_q - CntW'(1)));

  // The first entry always seeds the running minimum. Later entries replace it only when
  // strictly earlier: smaller fire time, or equal time and smaller id, so equal keys keep
  // the lowest slot.
  assign take = (cmp_idx_q == '0) ||
                (rd_entry.next_time < best_q.next_time) ||
                ((rd_entry.next_time == best_q.next_time) && (rd_entry.id < best_q.id));

  // Rescheduled fire time, saturating at the top of the time range.
  assign time_sum  = {1'b0, best_q.next_time} + (TimeW + 1)'(best_q.period);
  assign time_next = time_sum[TimeW] ? {TimeW{1'b1}} : time_sum[TimeW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (in_data_i.req_type == ReqNext) && (count_q != '0)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_last) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_d     = count_q;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IdxW-1:0];
    ram_wdata   = '{id: in_data_i.source_id, period: in_data_i.period,
                    next_time: TimeW'(in_data_i.period)};
    // While idle, slot zero is kept on the read port so that a scan can start at once.
    ram_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        cmp_idx_d = '0;
        if (accept) begin
          out_d = '{event_id: '0, event_time: '0, status: StOk};
          case (in_data_i.req_type)
            ReqInsert: begin
              out_valid_d = 1'b1;
              if (count_q >= CntW'(MaxSources)) begin
                out_d.status = StFull;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            ReqNext: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = StEmpty;
              end
            end
            ReqClear: begin
              out_valid_d = 1'b1;
              count_d     = '0;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      StScan: begin
        ram_raddr = cmp_idx_q + IdxW'(1);
        cmp_idx_d = cmp_idx_q + IdxW'(1);
        if (take) begin
          best_d     = rd_entry;
          best_idx_d = cmp_idx_q;
        end
      end
      StWrite: begin
        ram_we      = 1'b1;
        ram_waddr   = best_idx_q;
        ram_wdata   = '{id: best_q.id, period: best_q.period, next_time: time_next};
        out_valid_d = 1'b1;
        out_d       = '{event_id: best_q.id, event_time: best_q.next_time, status: StOk};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_idx_q   <= cmp_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  pes_ram #(
    .Width (EntryW),
    .Depth (MaxSources)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The table never holds more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSources))
    else $error("entry count above table size");

  // No response can be pending while a scan runs; the slot was freed when the request
  // was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> !out_valid_q)
    else $error("response pending during scan");

  // The entry written back after a scan is a valid slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> ({1'b0, best_idx_q} < count_q))
    else $error("write-back outside valid slots");

  // An empty-table response carries no event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == StEmpty)) |->
      ((out_q.event_id == '0) && (out_q.event_time == '0)))
    else $error("empty response carries an event");

  // A scan ends in the write-back cycle, which produces the response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> (out_valid_q && (state_q == StIdle)))
    else $error("write-back did not post a response");

endmodule

`default_nettype wire
